FILE: hw/rtl/icsum_pkg.sv
// Shared types, constants and the ones'-complement fold for the Internet
// checksum block. No dependencies; every other file in hw/rtl uses it.
package icsum_pkg;

    localparam int unsigned SUM_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WIDE_W     = 19;  // room for seven 16-bit terms
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned TDATA_W    = 104; // byte, seed, source, destination
    localparam int unsigned TUSER_W    = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    // Header byte counter: length word completes at byte 5, count stops at 6
    localparam logic [IDX_W-1:0] IDX_LEN_LOW = 3'd5;
    localparam logic [IDX_W-1:0] IDX_SAT     = 3'd6;

    localparam logic [BYTE_W-1:0] PROTOCOL_RESET = 8'd17;
    localparam logic              MODE_RESET     = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTPUT_MODE = 1'b0,
        REG_PROTOCOL    = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_COMPLEMENT = 1'b0,
        MODE_RAW_SUM    = 1'b1
    } out_mode_t;

    // Item held between the input stage and the accumulator
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
        logic              use_pseudo_header;
        logic [SUM_W-1:0]  init_sum;
    } item_t;

    // Fold a sum of several 16-bit terms with end-around carry
    function automatic logic [SUM_W-1:0] oc_fold(input logic [WIDE_W-1:0] t);
        logic [SUM_W:0] s;
        s = {1'b0, t[SUM_W-1:0]} + {{(SUM_W+1-(WIDE_W-SUM_W)){1'b0}}, t[WIDE_W-1:SUM_W]};
        return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
    endfunction

endpackage

FILE: hw/rtl/icsum_in_stage.sv
// Input register of the checksum block: captures one byte item and
// precomputes the restart sum (seed plus optional pseudo-header). Uses icsum_pkg.
module icsum_in_stage (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [icsum_pkg::TDATA_W-1:0]         s_tdata,
    input  logic [icsum_pkg::TUSER_W-1:0]         s_tuser,
    input  logic                                  s_tlast,
    input  logic [icsum_pkg::BYTE_W-1:0]          protocol_number,
    output logic                                  s1_valid,
    output icsum_pkg::item_t                      s1_item,
    input  logic                                  s1_ready
);

    logic                    valid_reg;
    logic                    valid_next;
    icsum_pkg::item_t        item_reg;
    icsum_pkg::item_t        item_next;
    logic                    accept;
    logic [icsum_pkg::WIDE_W-1:0] total;

    assign s_tready = !valid_reg || s1_ready;
    assign accept   = s_tvalid && s_tready;

    // Seed halves always; address halves and protocol word only with pseudo-header
    always_comb begin
        total = icsum_pkg::WIDE_W'(s_tdata[23:8]) + icsum_pkg::WIDE_W'(s_tdata[39:24]);
        if (s_tuser[1]) begin
            total = total
                  + icsum_pkg::WIDE_W'(s_tdata[55:40]) + icsum_pkg::WIDE_W'(s_tdata[71:56])
                  + icsum_pkg::WIDE_W'(s_tdata[87:72]) + icsum_pkg::WIDE_W'(s_tdata[103:88])
                  + icsum_pkg::WIDE_W'(protocol_number);
        end
    end

    always_comb begin
        item_next.data_byte         = s_tdata[7:0];
        item_next.first_byte        = s_tuser[0];
        item_next.last_byte         = s_tlast;
        item_next.use_pseudo_header = s_tuser[1];
        item_next.init_sum          = icsum_pkg::oc_fold(total);
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (s1_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

FILE: hw/rtl/icsum_accum.sv
// Running ones'-complement accumulator and result register of the checksum
// block. Uses icsum_pkg.
module icsum_accum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s1_valid,
    input  icsum_pkg::item_t                  s1_item,
    output logic                              s1_ready,
    input  logic                              output_mode,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [icsum_pkg::SUM_W-1:0]       m_tdata
);

    logic [icsum_pkg::SUM_W-1:0]  sum_reg,    sum_next;
    logic                         odd_reg,    odd_next;
    logic [icsum_pkg::BYTE_W-1:0] held_reg,   held_next;
    logic [icsum_pkg::IDX_W-1:0]  idx_reg,    idx_next;
    logic                         pseudo_reg, pseudo_next;
    logic                         mvalid_reg, mvalid_next;
    logic [icsum_pkg::SUM_W-1:0]  mdata_reg,  mdata_next;

    logic                         fire;
    logic [icsum_pkg::SUM_W-1:0]  base;
    logic                         odd_eff;
    logic [icsum_pkg::IDX_W-1:0]  idx_eff;
    logic                         pseudo_eff;
    logic [icsum_pkg::SUM_W-1:0]  word;
    logic [icsum_pkg::SUM_W-1:0]  add_a;
    logic [icsum_pkg::SUM_W-1:0]  add_b;
    logic [icsum_pkg::WIDE_W-1:0] total;

    // A byte that ends a packet needs a free output slot; others only update state
    assign s1_ready = !s1_item.last_byte || !mvalid_reg || m_tready;
    assign fire     = s1_valid && s1_ready;

    always_comb begin
        base       = s1_item.first_byte ? s1_item.init_sum : sum_reg;
        odd_eff    = s1_item.first_byte ? 1'b0 : odd_reg;
        idx_eff    = s1_item.first_byte ? '0 : idx_reg;
        pseudo_eff = s1_item.first_byte ? s1_item.use_pseudo_header : pseudo_reg;
        word       = {held_reg, s1_item.data_byte};

        add_a = '0;
        add_b = '0;
        if (odd_eff) begin
            add_a = word;
            // length word of the pseudo-header counts twice
            if (pseudo_eff && idx_eff == icsum_pkg::IDX_LEN_LOW) begin
                add_b = word;
            end
        end else if (s1_item.last_byte) begin
            add_a = {s1_item.data_byte, {icsum_pkg::BYTE_W{1'b0}}};
        end
        total = icsum_pkg::WIDE_W'(base) + icsum_pkg::WIDE_W'(add_a)
              + icsum_pkg::WIDE_W'(add_b);
    end

    always_comb begin
        sum_next    = sum_reg;
        odd_next    = odd_reg;
        held_next   = held_reg;
        idx_next    = idx_reg;
        pseudo_next = pseudo_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        if (fire) begin
            sum_next    = icsum_pkg::oc_fold(total);
            odd_next    = !odd_eff;
            held_next   = odd_eff ? held_reg : s1_item.data_byte;
            idx_next    = (idx_eff < icsum_pkg::IDX_SAT) ? idx_eff + 1'b1 : idx_eff;
            pseudo_next = pseudo_eff;
            if (s1_item.last_byte) begin
                mvalid_next = 1'b1;
                mdata_next  = (output_mode == icsum_pkg::MODE_COMPLEMENT) ?
                              ~icsum_pkg::oc_fold(total) : icsum_pkg::oc_fold(total);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            odd_reg    <= 1'b0;
            held_reg   <= '0;
            idx_reg    <= '0;
            pseudo_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            sum_reg    <= sum_next;
            odd_reg    <= odd_next;
            held_reg   <= held_next;
            idx_reg    <= idx_next;
            pseudo_reg <= pseudo_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

FILE: hw/rtl/internet_checksum_udp_pseudo_top.sv
// Top level of the byte-serial Internet checksum with optional UDP pseudo-header.
// Depends on icsum_pkg, icsum_in_stage and icsum_accum.
//
// Takes one packet byte per item and returns the 16-bit ones'-complement
// checksum on the item marked tlast. The block accepts one item every clock
// cycle; a result passes the input register, then the accumulator stage
// with its three-input sum and end-around carry fold, which also loads the
// output register. Input only waits when a last byte meets an output
// register still holding an untaken result.
// An item with tuser bit 0 set restarts the sum from its folded seed, and
// with tuser bit 1 also adds source and destination addresses, the protocol
// word and the length word found in packet bytes 4 and 5. A last byte does
// not clear anything: bytes without a first mark extend the current sum.
// Registers: index 0 output_mode (0 complemented, 1 raw folded sum), index 1
// protocol_number (reset 17); write them only while the block is idle.
module internet_checksum_udp_pseudo_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input item channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] data_byte, [39:8] seed_sum, [71:40] source_address,
    // [103:72] dest_address
    input  logic [icsum_pkg::TDATA_W-1:0]       s_tdata,
    // [0] first_byte, [1] use_pseudo_header
    input  logic [icsum_pkg::TUSER_W-1:0]       s_tuser,
    input  logic                                s_tlast,   // last_byte
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] checksum
    output logic [icsum_pkg::SUM_W-1:0]         m_tdata,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [icsum_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [icsum_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                          mode_reg,  mode_next;
    logic [icsum_pkg::BYTE_W-1:0]  proto_reg, proto_next;

    logic                          s1_valid;
    logic                          s1_ready;
    icsum_pkg::item_t              s1_item;
    logic                          s1_fire;

    // Configuration writes are always accepted
    assign cfg_ready = 1'b1;

    always_comb begin
        mode_next  = mode_reg;
        proto_next = proto_reg;
        if (cfg_valid && cfg_ready) begin
            case (icsum_pkg::cfg_reg_t'(cfg_index))
                icsum_pkg::REG_OUTPUT_MODE: mode_next  = cfg_data[0];
                icsum_pkg::REG_PROTOCOL:    proto_next = cfg_data;
                default: begin
                    mode_next  = mode_reg;
                    proto_next = proto_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= icsum_pkg::MODE_RESET;
            proto_reg <= icsum_pkg::PROTOCOL_RESET;
        end else begin
            mode_reg  <= mode_next;
            proto_reg <= proto_next;
        end
    end

    // Capture the item and prefold seed and pseudo-header terms
    icsum_in_stage u_in_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .protocol_number (proto_reg),
        .s1_valid        (s1_valid),
        .s1_item         (s1_item),
        .s1_ready        (s1_ready)
    );

    // Advance the running sum and load the result register
    icsum_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .s1_ready    (s1_ready),
        .output_mode (mode_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    assign s1_fire = s1_valid && s1_ready;

    // An accepted item always lands in the input register
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid)
        else $error("accepted item missing from input register");

    // A last byte never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_item.last_byte) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // A new result only follows a last byte leaving the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s1_fire && s1_item.last_byte))
        else $error("result without a last byte");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for internet_checksum_udp_pseudo_top: streams packet bytes,
// predicts every checksum in step with the accepted items and checks each result.
// Depends on icsum_pkg and the checksum RTL under hw/rtl.
module tb;

    localparam int WATCHDOG_LIMIT  = 2000; // cycles with no handshake at all
    localparam int DRAIN_CYCLES    = 8;    // lets the two pipeline stages settle, with margin
    localparam int RANDOM_PER_PASS = 155;  // random items per configuration pass

    // One packet byte together with its sideband fields
    typedef struct packed {
        logic [icsum_pkg::BYTE_W-1:0] data;
        logic                         first;
        logic                         last;
        logic [31:0]                  seed;
        logic                         with_ph;
        logic [31:0]                  src_ip;
        logic [31:0]                  dst_ip;
    } pkt_byte_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [icsum_pkg::TDATA_W-1:0]    s_tdata   = '0;
    logic [icsum_pkg::TUSER_W-1:0]    s_tuser   = '0;
    logic                             s_tlast   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [icsum_pkg::SUM_W-1:0]      m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [icsum_pkg::CFG_IDX_W-1:0]  cfg_index = icsum_pkg::REG_OUTPUT_MODE;
    logic [icsum_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    internet_checksum_udp_pseudo_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Period 2: high for one unit, low for one
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Checksum predictor: own copy of the configuration and the sum state
    // ------------------------------------------------------------------
    icsum_pkg::out_mode_t         mode_q  = icsum_pkg::out_mode_t'(icsum_pkg::MODE_RESET);
    logic [icsum_pkg::BYTE_W-1:0] proto_q = icsum_pkg::PROTOCOL_RESET;
    logic [icsum_pkg::SUM_W-1:0]  sum_q   = '0;
    logic                         odd_q   = 1'b0; // 1: a high byte is held, waiting for its low byte
    logic [icsum_pkg::BYTE_W-1:0] hi_q    = '0;
    logic [icsum_pkg::IDX_W-1:0]  hdr_q   = '0;   // header byte counter, stops at six
    logic                         ph_q    = 1'b0; // pseudo-header active for this packet

    logic [icsum_pkg::SUM_W-1:0]  csum_due[$];    // checksums still to come out, oldest first
    pkt_byte_t                    byte_queue[$];  // bytes waiting for the driver

    int errors      = 0;
    int bytes_in    = 0;
    int sums_out    = 0;
    int cfg_writes  = 0;
    int idle_cycles = 0;
    int queued      = 0;
    bit quiet_pass  = 1'b0; // no idling on either side while set

    function automatic logic [icsum_pkg::SUM_W-1:0] ones_add(
        input logic [icsum_pkg::SUM_W-1:0] a,
        input logic [icsum_pkg::SUM_W-1:0] b);
        logic [icsum_pkg::SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[icsum_pkg::SUM_W-1:0] + {{(icsum_pkg::SUM_W-1){1'b0}}, s[icsum_pkg::SUM_W]};
    endfunction

    function automatic logic [icsum_pkg::SUM_W-1:0] fold_word(input logic [31:0] v);
        return ones_add(v[15:0], v[31:16]);
    endfunction

    // Advance the predicted state by one accepted byte; queue a checksum on a last byte
    task accumulate_byte(input pkt_byte_t b);
        logic [icsum_pkg::SUM_W-1:0] word;
        logic [icsum_pkg::SUM_W-1:0] r;
        if (b.first) begin
            r = fold_word(b.seed);
            if (b.with_ph) begin
                r = ones_add(r, fold_word(b.src_ip));
                r = ones_add(r, fold_word(b.dst_ip));
                r = ones_add(r, {8'h00, proto_q});
            end
            sum_q = r;
            odd_q = 1'b0;
            hi_q  = '0;
            hdr_q = '0;
            ph_q  = b.with_ph;
        end
        if (!odd_q) begin
            hi_q  = b.data;
            odd_q = 1'b1;
            // trailing odd byte: pad with a zero low byte
            if (b.last)
                sum_q = ones_add(sum_q, {b.data, 8'h00});
        end else begin
            word  = {hi_q, b.data};
            sum_q = ones_add(sum_q, word);
            // header bytes 4 and 5 double as the pseudo-header length word
            if (ph_q && hdr_q == icsum_pkg::IDX_LEN_LOW)
                sum_q = ones_add(sum_q, word);
            odd_q = 1'b0;
        end
        if (hdr_q < icsum_pkg::IDX_SAT)
            hdr_q = hdr_q + 1'b1;
        if (b.last) begin
            r = sum_q;
            if (mode_q == icsum_pkg::MODE_COMPLEMENT)
                r = ~r;
            csum_due.push_back(r);
        end
    endtask

    task report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Mostly short gaps, a few long ones; none during a quiet pass
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_pass || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed the input channel from byte_queue at the falling edge
    // ------------------------------------------------------------------
    pkt_byte_t cur_byte;
    bit        in_taken = 1'b0; // set at the rising edge when the held item was accepted
    int        in_gap   = 0;
    int        out_gap  = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold the item until the block takes it
        end else if (in_gap != 0) begin
            in_gap   = in_gap - 1;
            s_tvalid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
            cur_byte = byte_queue.pop_front();
            s_tdata  <= {cur_byte.dst_ip, cur_byte.src_ip, cur_byte.seed, cur_byte.data};
            s_tuser  <= {cur_byte.with_ph, cur_byte.first};
            s_tlast  <= cur_byte.last;
            s_tvalid <= 1'b1;
            in_gap   = gap_len();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Stall the result side at random; assign m_tready once per edge
    always @(negedge aclk) begin
        if (out_gap != 0) begin
            out_gap  = out_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                out_gap = gap_len();
        end
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog: sample every handshake at the rising edge
    // ------------------------------------------------------------------
    logic [icsum_pkg::SUM_W-1:0] want;

    always @(posedge aclk) begin
        in_taken = 1'b0;
        idle_cycles++;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                idle_cycles = 0;
                bytes_in++;
                accumulate_byte(cur_byte);
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                sums_out++;
                if (csum_due.size() == 0) begin
                    report_error($sformatf("unexpected checksum 0x%04h", m_tdata));
                end else begin
                    want = csum_due.pop_front();
                    if (m_tdata !== want)
                        report_error($sformatf("checksum 0x%04h, predicted 0x%04h",
                                               m_tdata, want));
                end
            end
            if (cfg_valid && cfg_ready) begin
                idle_cycles = 0;
                cfg_writes++;
                if (cfg_index == icsum_pkg::REG_OUTPUT_MODE)
                    mode_q = icsum_pkg::out_mode_t'(cfg_data[0]);
                else
                    proto_q = cfg_data;
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no handshake for %0d cycles, %0d checksums pending",
                     idle_cycles, csum_due.size());
            $display("internet_checksum_udp_pseudo_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task push_byte(input logic [7:0] d, input bit f, input bit l, input logic [31:0] seed,
                   input bit ph, input logic [31:0] src, input logic [31:0] dst);
        pkt_byte_t b;
        b.data    = d;
        b.first   = f;
        b.last    = l;
        b.seed    = seed;
        b.with_ph = ph;
        b.src_ip  = src;
        b.dst_ip  = dst;
        byte_queue.push_back(b);
        queued++;
    endtask

    // Random 32-bit value leaning toward the extremes now and then
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Queue one packet; fields that only the first byte reads carry junk elsewhere
    task push_packet(input int len, input bit ph, input bit mark_first, input bit mark_last);
        for (int i = 0; i < len; i++) begin
            if (i == 0 && mark_first)
                push_byte(8'($urandom), 1'b1, mark_last && len == 1, pick_word(), ph,
                          pick_word(), pick_word());
            else
                push_byte(8'($urandom), 1'b0, mark_last && i == len - 1, $urandom,
                          1'($urandom_range(0, 1)), $urandom, $urandom);
        end
    endtask

    // Random traffic: mostly well-formed packets, some loose bytes and broken packets
    task push_random(input int n);
        int stop;
        int r;
        int len;
        stop = queued + n;
        while (queued < stop) begin
            r = $urandom_range(0, 99);
            len = $urandom_range(0, 99);
            if (len < 10)
                len = $urandom_range(1, 2);
            else if (len < 85)
                len = $urandom_range(3, 16);
            else
                len = $urandom_range(17, 48);
            if (r < 85) begin
                push_packet(len, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
            end else if (r < 90) begin
                // bytes that extend the previous sum without a first mark
                push_packet($urandom_range(1, 5), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
            end else if (r < 95) begin
                // packet cut off before its last byte; the next first mark restarts
                push_packet(len, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
            end else begin
                push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
            end
        end
    endtask

    // Wait until every queued byte went in and every checksum came out, then let
    // the pipeline settle, since bytes without a last mark leave nothing to wait for.
    // Check at the rising edge, where the driven valid has already settled.
    task wait_drained();
        while (byte_queue.size() != 0 || s_tvalid || csum_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task write_reg(input icsum_pkg::cfg_reg_t idx,
                   input logic [icsum_pkg::CFG_DATA_W-1:0] val);
        int seen;
        seen = cfg_writes;
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        while (cfg_writes == seen)
            @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Configure both registers; the mode write carries random upper bits
    task set_config(input icsum_pkg::out_mode_t m, input logic [7:0] proto);
        write_reg(icsum_pkg::REG_OUTPUT_MODE, {7'($urandom_range(0, 127)), m});
        write_reg(icsum_pkg::REG_PROTOCOL, proto);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset configuration
        // bytes with no first mark right after reset extend the zero sum
        push_byte(8'hff, 1'b0, 1'b0, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        push_byte(8'h00, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, 32'h0000_0000);
        // first and last on one byte, all fields at their maximum
        push_byte(8'hff, 1'b1, 1'b1, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        // first and last on one byte, all zero
        push_byte(8'h00, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, 32'h0000_0000);
        // short pseudo-header packet: no length word
        push_byte(8'h12, 1'b1, 1'b0, 32'h0001_ffff, 1'b1, 32'hc0a8_0001, 32'h0a00_0002);
        push_byte(8'h34, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 32'h0);
        push_byte(8'h56, 1'b0, 1'b1, 32'h0, 1'b0, 32'h0, 32'h0);
        // eight-byte pseudo-header packet of 0xff bytes: length word counted twice
        push_byte(8'hff, 1'b1, 1'b0, 32'hffff_0000, 1'b1, 32'hffff_ffff, 32'h0000_ffff);
        for (int i = 1; i < 8; i++)
            push_byte(8'hff, 1'b0, i == 7, 32'h0, 1'b0, 32'h0, 32'h0);
        // bytes after a last byte carry on from the previous sum
        push_byte(8'h80, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 32'h0);
        push_byte(8'h01, 1'b0, 1'b1, 32'h0, 1'b0, 32'h0, 32'h0);
        // six-byte packet without pseudo-header, largest seed
        push_byte(8'h45, 1'b1, 1'b0, 32'hffff_ffff, 1'b0, 32'h1234_5678, 32'h9abc_def0);
        for (int i = 1; i < 6; i++)
            push_byte(8'($urandom), 1'b0, i == 5, 32'h0, 1'b0, 32'h0, 32'h0);
        push_random(RANDOM_PER_PASS);
        wait_drained();

        // Raw sum, protocol zero
        set_config(icsum_pkg::MODE_RAW_SUM, 8'h00);
        push_random(RANDOM_PER_PASS);
        wait_drained();

        // Complemented, protocol at its maximum, no idling on either side
        quiet_pass = 1'b1;
        set_config(icsum_pkg::MODE_COMPLEMENT, 8'hff);
        push_random(RANDOM_PER_PASS);
        wait_drained();
        quiet_pass = 1'b0;

        set_config(icsum_pkg::MODE_RAW_SUM, 8'hff);
        push_random(RANDOM_PER_PASS);
        wait_drained();

        set_config(icsum_pkg::MODE_COMPLEMENT, 8'($urandom_range(0, 255)));
        push_random(RANDOM_PER_PASS);
        wait_drained();

        set_config(icsum_pkg::out_mode_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        push_random(RANDOM_PER_PASS);
        wait_drained();

        $display("Covered %0d bytes and %0d checksums over %0d register writes,",
                 bytes_in, sums_out, cfg_writes);
        $display("both output modes, protocol 0, 255 and random, with and without stalls.");
        if (errors == 0)
            $display("internet_checksum_udp_pseudo_top verification clean");
        else
            $display("internet_checksum_udp_pseudo_top verification failed");
        $finish;
    end

endmodule
